// ===== rtl/skne_pkg.sv =====
// ----------------------------------------------------------------------------
// skne_pkg: shared types and constants of the sorted key node engine
// Request and response structs, action and status codes, register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skne_pkg;

	localparam int NODE_MAX   = 64;
	localparam int KEY_BITS   = 32;
	localparam int DATA_BITS  = 32;
	localparam int IDX_W      = 7;
	localparam int SLOT_W     = 6;
	localparam int KEY_AW     = $clog2(NODE_MAX);
	localparam int VAL_AW     = $clog2(NODE_MAX + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEAF     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNED   = 2'd2;

	typedef enum logic [2:0] {
		ACT_ADD      = 3'd0,
		ACT_SEARCH   = 3'd1,
		ACT_ROUTE    = 3'd2,
		ACT_HIDE     = 3'd3,
		ACT_UNHIDE   = 3'd4,
		ACT_TEST     = 3'd5,
		ACT_READ     = 3'd6,
		ACT_SET_LEFT = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		action_t               action;
		logic [31:0]           search_key;
		logic [31:0]           entry_value;
		logic [SLOT_W-1:0]     slot_index;
		logic                  update_existing;
		logic                  has_value;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [IDX_W-1:0]      result_slot;
		logic                  key_found;
		logic                  wrote;
		logic                  hidden_flag;
		logic [31:0]           key_out;
		logic [31:0]           value_out;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/skne_ram.sv =====
// ----------------------------------------------------------------------------
// skne_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skne_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/sorted_key_node_engine_unit.sv =====
// Sequencing: slot actions, set leftmost and a full add go straight to the
//   response (read waits for its RAM data); search, route and add probe at most
//   7 times, route then reads the child, insert moves entries right (up to 63).
// Throughput: one request at a time; a new one is taken once the previous
//   response is registered, set by the single key comparator and key RAM.
// Reset: count zero, all hidden marks clear, registers leaf/64/unsigned.
// ----------------------------------------------------------------------------
// sorted_key_node_engine_unit: one sorted B+tree node with a probe sequencer
// Keys and values live in RAMs; one comparator runs the binary search and
// insert moves entries right one at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_node_engine_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire skne_pkg::req_t                    req,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output skne_pkg::rsp_t                         rsp,
	input  wire logic                              cfg_we,
	input  wire logic [skne_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [skne_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		IDLE, PROBE, CMP, POST, SHIFT_RD, SHIFT_WR, INS, FIN
	} state_t;

	localparam int IW = skne_pkg::IDX_W;
	localparam int KAW = skne_pkg::KEY_AW;
	localparam int VAW = skne_pkg::VAL_AW;
	localparam int NM = skne_pkg::NODE_MAX;
	localparam int KB = skne_pkg::KEY_BITS;
	localparam int DB = skne_pkg::DATA_BITS;

	state_t                 state_q;
	logic                   leaf_q, signed_q;
	logic [IW-1:0]          cap_q, count_q;
	logic [NM-1:0]          hid_q;
	skne_pkg::req_t         req_q;
	skne_pkg::rsp_t         res_q;
	logic [IW-1:0]          lo_q, hi_q, best_q, mid_q, pos_q;
	logic                   found_q, rd_wait_q;

	logic [IW-1:0]          limit, mid, vofs, s_route;
	logic [IW:0]            mid_sum;
	logic [KB-1:0]          key_rd, cmp_a, cmp_b;
	logic [DB-1:0]          val_rd;
	logic                   k_we, v_we;
	logic [KAW-1:0]         k_wa, k_ra;
	logic [VAW-1:0]         v_wa, v_ra;
	logic [KB-1:0]          k_wd;
	logic [DB-1:0]          v_wd;
	logic [NM-1:0]          h_prev, h_ins;
	logic                   slot_ok, accept;
	skne_pkg::rsp_t         acc_res;
	state_t                 acc_state;
	logic                   acc_rd, hid_we, hid_val, rsp_load;

	assign limit   = (cap_q < IW'(NM)) ? cap_q : IW'(NM);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (IW+1)'(1);
	assign mid     = mid_sum[IW:1];
	assign vofs    = leaf_q ? IW'(0) : IW'(1);
	assign s_route = best_q + IW'(found_q);
	assign slot_ok = {1'b0, req.slot_index} < count_q;
	assign accept  = req_valid && !req_stall;
	assign req_stall = (state_q != IDLE);
	assign rsp_load = (state_q == FIN) && !rd_wait_q && (!rsp_valid || !rsp_stall);

	// compare keys, flipping the sign bit for signed order
	assign cmp_a = req_q.search_key[KB-1:0] ^ {signed_q, {(KB-1){1'b0}}};
	assign cmp_b = key_rd ^ {signed_q, {(KB-1){1'b0}}};

	// hidden marks after an insert at best_q
	assign h_prev = {hid_q[NM-2:0], 1'b0};
	always_comb begin
		for (int i = 0; i < NM; i++) begin
			if (IW'(i) == best_q) begin
				h_ins[i] = 1'b0;
			end else if (IW'(i) > best_q && IW'(i) <= count_q) begin
				h_ins[i] = h_prev[i];
			end else begin
				h_ins[i] = hid_q[i];
			end
		end
	end

	// decode a request taken in idle
	always_comb begin
		acc_res   = '0;
		acc_state = FIN;
		acc_rd    = 1'b0;
		hid_we    = 1'b0;
		hid_val   = 1'b0;
		case (req.action) inside
			skne_pkg::ACT_ADD: begin
				if (count_q >= limit) begin
					acc_res.status = skne_pkg::ST_FULL;
				end else begin
					acc_state = PROBE;
				end
			end
			skne_pkg::ACT_SEARCH, skne_pkg::ACT_ROUTE: begin
				if (count_q == '0) begin
					acc_res.status = skne_pkg::ST_EMPTY;
				end else begin
					acc_state = PROBE;
				end
			end
			skne_pkg::ACT_SET_LEFT: begin
			end
			default: begin
				acc_res.result_slot = IW'(req.slot_index);
				if (!slot_ok) begin
					acc_res.status = skne_pkg::ST_RANGE;
				end else if (req.action == skne_pkg::ACT_HIDE) begin
					hid_we              = 1'b1;
					hid_val             = 1'b1;
					acc_res.hidden_flag = 1'b1;
				end else if (req.action == skne_pkg::ACT_UNHIDE) begin
					hid_we = 1'b1;
				end else begin
					acc_res.hidden_flag = hid_q[req.slot_index];
					acc_rd = (req.action == skne_pkg::ACT_READ);
				end
			end
		endcase
	end

	// steer the RAM ports by state
	always_comb begin
		k_we = 1'b0;
		v_we = 1'b0;
		k_wa = '0;
		v_wa = '0;
		k_wd = req_q.search_key[KB-1:0];
		v_wd = req_q.entry_value[DB-1:0];
		k_ra = req.slot_index;
		v_ra = VAW'(req.slot_index);
		unique case (state_q)
			IDLE: begin
				if (accept && req.action == skne_pkg::ACT_SET_LEFT) begin
					v_we = 1'b1;
					v_wa = '0;
					v_wd = req.entry_value[DB-1:0];
				end
			end
			PROBE: begin
				k_ra = mid[KAW-1:0];
			end
			POST: begin
				v_ra = VAW'(s_route);
				if (req_q.action == skne_pkg::ACT_ADD && found_q && leaf_q &&
						req_q.has_value && req_q.update_existing) begin
					v_we = 1'b1;
					v_wa = VAW'(best_q);
				end
			end
			SHIFT_RD: begin
				k_ra = KAW'(pos_q - IW'(1));
				v_ra = VAW'(pos_q - IW'(1) + vofs);
			end
			SHIFT_WR: begin
				k_we = 1'b1;
				k_wa = pos_q[KAW-1:0];
				k_wd = key_rd;
				v_we = req_q.has_value;
				v_wa = VAW'(pos_q + vofs);
				v_wd = val_rd;
			end
			INS: begin
				k_we = 1'b1;
				k_wa = best_q[KAW-1:0];
				v_we = req_q.has_value;
				v_wa = VAW'(best_q + vofs);
			end
			default: begin
			end
		endcase
	end

	skne_ram #(.WIDTH(KB), .DEPTH(NM)) u_key_ram (
		.clk     (clk),
		.we      (k_we),
		.wr_addr (k_wa),
		.wr_data (k_wd),
		.rd_addr (k_ra),
		.rd_data (key_rd)
	);

	skne_ram #(.WIDTH(DB), .DEPTH(NM + 1)) u_val_ram (
		.clk     (clk),
		.we      (v_we),
		.wr_addr (v_wa),
		.wr_data (v_wd),
		.rd_addr (v_ra),
		.rd_data (val_rd)
	);

	// sequencer, node state and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			leaf_q    <= 1'b1;
			cap_q     <= IW'(64);
			signed_q  <= 1'b0;
			count_q   <= '0;
			hid_q     <= '0;
			rsp_valid <= 1'b0;
			rd_wait_q <= 1'b0;
		end else begin
			// load a new response, or drop one once taken
			if (rsp_load) begin
				rsp_valid <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					skne_pkg::CFG_LEAF:     leaf_q   <= cfg_data[0];
					skne_pkg::CFG_CAPACITY: cap_q    <= cfg_data[IW-1:0];
					skne_pkg::CFG_SIGNED:   signed_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						req_q     <= req;
						res_q     <= acc_res;
						lo_q      <= '0;
						hi_q      <= count_q;
						best_q    <= count_q;
						found_q   <= 1'b0;
						rd_wait_q <= acc_rd;
						state_q   <= acc_state;
						if (hid_we) begin
							hid_q[req.slot_index] <= hid_val;
						end
					end
				end
				PROBE: begin
					mid_q <= mid;
					state_q <= (lo_q < hi_q) ? CMP : POST;
				end
				CMP: begin
					if (cmp_a == cmp_b) begin
						found_q <= 1'b1;
						best_q  <= mid_q;
						state_q <= POST;
					end else if (cmp_a < cmp_b) begin
						hi_q <= mid_q;
						if (mid_q < best_q) begin
							best_q <= mid_q;
						end
						state_q <= PROBE;
					end else begin
						lo_q    <= mid_q + IW'(1);
						state_q <= PROBE;
					end
				end
				POST: begin
					res_q.key_found   <= found_q;
					res_q.result_slot <= (req_q.action == skne_pkg::ACT_ROUTE) ?
						s_route : best_q;
					case (req_q.action)
						skne_pkg::ACT_ADD: begin
							if (found_q) begin
								if (leaf_q) begin
									res_q.wrote <= 1'b1;
									hid_q[best_q[KAW-1:0]] <= 1'b0;
								end
								state_q <= FIN;
							end else begin
								pos_q   <= count_q;
								state_q <= SHIFT_RD;
							end
						end
						skne_pkg::ACT_SEARCH: begin
							if (best_q < count_q) begin
								res_q.hidden_flag <= hid_q[best_q[KAW-1:0]];
							end
							state_q <= FIN;
						end
						default: begin
							// route: fetch the child
							rd_wait_q <= 1'b1;
							state_q   <= FIN;
						end
					endcase
				end
				SHIFT_RD: begin
					state_q <= (pos_q > best_q) ? SHIFT_WR : INS;
				end
				SHIFT_WR: begin
					pos_q   <= pos_q - IW'(1);
					state_q <= SHIFT_RD;
				end
				INS: begin
					hid_q       <= h_ins;
					count_q     <= count_q + IW'(1);
					res_q.wrote <= 1'b1;
					state_q     <= FIN;
				end
				FIN: begin
					// read data arrives in the cycle after its address
					if (rd_wait_q) begin
						rd_wait_q       <= 1'b0;
						res_q.value_out <= 32'(val_rd);
						if (req_q.action == skne_pkg::ACT_READ) begin
							res_q.key_out <= 32'(key_rd);
						end
					end else if (rsp_load) begin
						rsp     <= res_q;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= IW'(NM))
		else $error("entry count beyond node size");

	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == skne_pkg::ST_FULL |-> !rsp.wrote)
		else $error("write reported on a full node");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.key_found |-> rsp.status == skne_pkg::ST_OK)
		else $error("key found with error status");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(state_q) == INS)
		else $error("entry count changed outside insert");
`endif

endmodule

`default_nettype wire
